// ===== rtl/core/mi3_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared widths, payload types and inter-stage structs for the 3x3 inverse.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int IN_W     = 16;
  localparam int OUT_W    = 32;
  localparam int IN_FRAC  = IN_W / 2;
  localparam int OUT_FRAC = OUT_W / 2;
  localparam int PROD_W   = 2 * IN_W;
  localparam int COF_W    = 2 * IN_W + 1;
  localparam int COFM_W   = 2 * IN_W;
  localparam int DP_W     = IN_W + COF_W;
  localparam int DET_W    = 3 * IN_W + 3;
  localparam int DMAG_W   = DET_W - 1;
  localparam int FRAC_SH  = IN_FRAC + OUT_FRAC + 1;
  localparam int N_W      = COFM_W + FRAC_SH + 1;
  localparam int D_W      = DMAG_W + 1;
  localparam int LANES    = 9;
  localparam int FRONT_STAGES = 6;
  localparam int LATENCY  = FRONT_STAGES + OUT_W + 2;

  typedef struct packed {
    logic signed [IN_W-1:0] in_r0_c0;
    logic signed [IN_W-1:0] in_r1_c0;
    logic signed [IN_W-1:0] in_r2_c0;
    logic signed [IN_W-1:0] in_r0_c1;
    logic signed [IN_W-1:0] in_r1_c1;
    logic signed [IN_W-1:0] in_r2_c1;
    logic signed [IN_W-1:0] in_r0_c2;
    logic signed [IN_W-1:0] in_r1_c2;
    logic signed [IN_W-1:0] in_r2_c2;
  } matrix_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] out_r0_c0;
    logic signed [OUT_W-1:0] out_r1_c0;
    logic signed [OUT_W-1:0] out_r2_c0;
    logic signed [OUT_W-1:0] out_r0_c1;
    logic signed [OUT_W-1:0] out_r1_c1;
    logic signed [OUT_W-1:0] out_r2_c1;
    logic signed [OUT_W-1:0] out_r0_c2;
    logic signed [OUT_W-1:0] out_r1_c2;
    logic signed [OUT_W-1:0] out_r2_c2;
    logic                    singular;
  } inverse_t;

  // per-lane operands from the front end
  typedef struct packed {
    logic [COFM_W-1:0]      kmag;
    logic                   kneg;
    logic signed [IN_W-1:0] entry;
  } lane_in_t;

  // determinant info shared by all lanes
  typedef struct packed {
    logic              valid;
    logic              dneg;
    logic              singular;
    logic [DMAG_W-1:0] dmag;
  } shared_t;

  typedef struct packed {
    logic                   valid;
    logic                   neg;
    logic                   ovf;
    logic [OUT_W-1:0]       q;
    logic                   singular;
    logic signed [IN_W-1:0] entry;
  } lane_out_t;

endpackage
`default_nettype wire

// ===== rtl/core/matrix3x3_inverse_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix3x3_inverse_top
// 3x3 fixed-point matrix inverse by the adjugate, one matrix per cycle.
// ----------------------------------------------------------------------------
// A request is taken on every cycle that start is high; busy never rises, so
// one matrix can enter each clock. Each result passes through the cofactor and
// determinant arithmetic stages, one divider setup stage, 32 one-bit restoring
// divider stages in each of nine lanes and one output register, and is shown
// for a single cycle with done high. The receiver cannot stall the block and
// must take every result when it comes.
// A singular matrix comes back rescaled to Q16.16 with singular set.
module matrix3x3_inverse_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  mi3_pkg::matrix_t  matrix,
  output logic              busy,
  output logic              done,
  output mi3_pkg::inverse_t inverse
);
  import mi3_pkg::*;

  shared_t   shared;
  lane_in_t  lane_in  [LANES];
  lane_out_t lane_out [LANES];
  logic      accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  mi3_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .matrix  (matrix),
    .shared  (shared),
    .lane_in (lane_in)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    mi3_div_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .shared   (shared),
      .lane_in  (lane_in[l]),
      .lane_out (lane_out[l])
    );
  end

  mi3_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .lane_out (lane_out),
    .done     (done),
    .inverse  (inverse)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done) else $error("result missing after request");

  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done) else $error("result right after reset");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    lane_out[0].valid == lane_out[LANES-1].valid)
    else $error("lanes out of step");

  a_singular_pass: assert property (@(posedge clk) disable iff (rst)
    done && inverse.singular |-> inverse.out_r1_c1[OUT_FRAC-IN_FRAC-1:0] == '0)
    else $error("singular pass-through not rescaled");

endmodule
`default_nettype wire

// ===== rtl/core/mi3_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_front
// Cofactors and determinant, six register stages.
// ----------------------------------------------------------------------------
module mi3_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  mi3_pkg::matrix_t  matrix,
  output mi3_pkg::shared_t  shared,
  output mi3_pkg::lane_in_t lane_in [mi3_pkg::LANES]
);
  import mi3_pkg::*;

  logic [FRONT_STAGES-1:0] vld;

  logic signed [IN_W-1:0]   m1 [3][3];
  logic signed [IN_W-1:0]   m2 [3][3];
  logic signed [IN_W-1:0]   m3 [3][3];
  logic signed [IN_W-1:0]   m4 [3][3];
  logic signed [IN_W-1:0]   m5 [3][3];
  logic signed [IN_W-1:0]   m6 [3][3];
  logic signed [PROD_W-1:0] pa [3][3];
  logic signed [PROD_W-1:0] pb [3][3];
  logic signed [COF_W-1:0]  cof3 [3][3];
  logic signed [COF_W-1:0]  cof4 [3][3];
  logic signed [COF_W-1:0]  cof5 [3][3];
  logic signed [DP_W-1:0]   dp [3];
  logic signed [DET_W-1:0]  det;
  logic [COFM_W-1:0]        kmag [3][3];
  logic                     kneg [3][3];
  logic                     dneg;
  logic                     sing;
  logic [DMAG_W-1:0]        dmag;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[FRONT_STAGES-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    m1[0][0] <= matrix.in_r0_c0;
    m1[1][0] <= matrix.in_r1_c0;
    m1[2][0] <= matrix.in_r2_c0;
    m1[0][1] <= matrix.in_r0_c1;
    m1[1][1] <= matrix.in_r1_c1;
    m1[2][1] <= matrix.in_r2_c1;
    m1[0][2] <= matrix.in_r0_c2;
    m1[1][2] <= matrix.in_r1_c2;
    m1[2][2] <= matrix.in_r2_c2;
    m2 <= m1;
    m3 <= m2;
    m4 <= m3;
    m5 <= m4;
    m6 <= m5;
    cof4 <= cof3;
    cof5 <= cof4;
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      localparam int R1 = (r + 1) % 3;
      localparam int R2 = (r + 2) % 3;
      localparam int C1 = (c + 1) % 3;
      localparam int C2 = (c + 2) % 3;
      always_ff @(posedge clk) begin
        pa[r][c]   <= m1[R1][C1] * m1[R2][C2];
        pb[r][c]   <= m1[R1][C2] * m1[R2][C1];
        cof3[r][c] <= COF_W'(pa[r][c]) - COF_W'(pb[r][c]);
        kneg[r][c] <= cof5[r][c][COF_W-1];
        kmag[r][c] <= cof5[r][c][COF_W-1] ? COFM_W'(-cof5[r][c]) : COFM_W'(cof5[r][c]);
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_dp
    always_ff @(posedge clk) begin
      dp[c] <= m3[0][c] * cof3[0][c];
    end
  end

  always_ff @(posedge clk) begin
    det  <= DET_W'(dp[0]) + DET_W'(dp[1]) + DET_W'(dp[2]);
    dneg <= det[DET_W-1];
    sing <= (det == '0);
    dmag <= det[DET_W-1] ? DMAG_W'(-det) : DMAG_W'(det);
  end

  assign shared.valid    = vld[FRONT_STAGES-1];
  assign shared.dneg     = dneg;
  assign shared.singular = sing;
  assign shared.dmag     = dmag;

  // lane 3*c+r produces inverse entry (r,c) from cofactor (c,r)
  for (genvar c = 0; c < 3; c++) begin : g_lc
    for (genvar r = 0; r < 3; r++) begin : g_lr
      assign lane_in[3*c+r].kmag  = kmag[c][r];
      assign lane_in[3*c+r].kneg  = kneg[c][r];
      assign lane_in[3*c+r].entry = m6[r][c];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mi3_div_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_div_lane
// Pipelined restoring divider, one quotient bit per stage, rounding to
// nearest by dividing (2n + d) by 2d.
// ----------------------------------------------------------------------------
module mi3_div_lane (
  input  logic               clk,
  input  logic               rst,
  input  mi3_pkg::shared_t   shared,
  input  mi3_pkg::lane_in_t  lane_in,
  output mi3_pkg::lane_out_t lane_out
);
  import mi3_pkg::*;

  typedef struct packed {
    logic                   neg;
    logic                   ovf;
    logic                   singular;
    logic signed [IN_W-1:0] entry;
    logic [D_W-1:0]         den;
    logic [D_W-1:0]         rem;
    logic [OUT_W-1:0]       low;
    logic [OUT_W-1:0]       q;
  } stg_t;

  logic [OUT_W:0] vld;
  stg_t           st [OUT_W+1];

  logic [N_W-1:0] num;
  logic [D_W-1:0] den;
  logic [N_W-OUT_W-1:0] top;

  always_comb begin
    num = (N_W'(lane_in.kmag) << FRAC_SH) + N_W'(shared.dmag);
    den = {shared.dmag, 1'b0};
    top = num[N_W-1:OUT_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[OUT_W-1:0], shared.valid};
    end
  end

  always_ff @(posedge clk) begin
    st[0].neg      <= lane_in.kneg ^ shared.dneg;
    // quotient would need more than OUT_W bits (always so for zero divisor)
    st[0].ovf      <= (D_W'(top) >= den);
    st[0].singular <= shared.singular;
    st[0].entry    <= lane_in.entry;
    st[0].den      <= den;
    st[0].rem      <= D_W'(top);
    st[0].low      <= num[OUT_W-1:0];
    st[0].q        <= '0;
  end

  for (genvar s = 1; s <= OUT_W; s++) begin : g_stage
    logic [D_W:0] trial;
    logic         ge;
    always_comb begin
      trial = {st[s-1].rem, st[s-1].low[OUT_W-1]};
      ge    = (trial >= {1'b0, st[s-1].den});
    end
    always_ff @(posedge clk) begin
      st[s].neg      <= st[s-1].neg;
      st[s].ovf      <= st[s-1].ovf;
      st[s].singular <= st[s-1].singular;
      st[s].entry    <= st[s-1].entry;
      st[s].den      <= st[s-1].den;
      st[s].rem      <= ge ? D_W'(trial - {1'b0, st[s-1].den}) : D_W'(trial);
      st[s].low      <= {st[s-1].low[OUT_W-2:0], 1'b0};
      st[s].q        <= {st[s-1].q[OUT_W-2:0], ge};
    end
  end

  assign lane_out.valid    = vld[OUT_W];
  assign lane_out.neg      = st[OUT_W].neg;
  assign lane_out.ovf      = st[OUT_W].ovf;
  assign lane_out.q        = st[OUT_W].q;
  assign lane_out.singular = st[OUT_W].singular;
  assign lane_out.entry    = st[OUT_W].entry;

endmodule
`default_nettype wire

// ===== rtl/core/mi3_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_merge
// Saturates the nine quotients, selects pass-through on a singular matrix
// and registers the result.
// ----------------------------------------------------------------------------
module mi3_merge (
  input  logic               clk,
  input  logic               rst,
  input  mi3_pkg::lane_out_t lane_out [mi3_pkg::LANES],
  output logic               done,
  output mi3_pkg::inverse_t  inverse
);
  import mi3_pkg::*;

  logic [OUT_W-1:0] val [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_sat
    logic [OUT_W-1:0] lim;
    logic [OUT_W-1:0] mag;
    logic [OUT_W-1:0] pass;
    always_comb begin
      lim  = lane_out[l].neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
      mag  = (lane_out[l].ovf || lane_out[l].q > lim) ? lim : lane_out[l].q;
      pass = OUT_W'(lane_out[l].entry) << (OUT_FRAC - IN_FRAC);
      if (lane_out[l].singular) begin
        val[l] = pass;
      end else begin
        val[l] = lane_out[l].neg ? -mag : mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= lane_out[0].valid;
    end
  end

  always_ff @(posedge clk) begin
    inverse.out_r0_c0 <= val[0];
    inverse.out_r1_c0 <= val[1];
    inverse.out_r2_c0 <= val[2];
    inverse.out_r0_c1 <= val[3];
    inverse.out_r1_c1 <= val[4];
    inverse.out_r2_c1 <= val[5];
    inverse.out_r0_c2 <= val[6];
    inverse.out_r1_c2 <= val[7];
    inverse.out_r2_c2 <= val[8];
    inverse.singular  <= lane_out[0].singular;
  end

endmodule
`default_nettype wire
